@@ rtl/qat_pkg.sv @@
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and constants for the quote-aware byte tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qat_pkg;

    // Byte codes with a meaning of their own
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Configuration port geometry
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned MASK_WORDS = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK_3 = 3'd3;

    // Reset value of the first mask word: space only
    localparam logic [CFG_DATA_W-1:0] SEP_MASK_0_RESET = 64'h0000_0001_0000_0000;

    // Tokenizer state carried from byte to byte
    typedef struct packed {
        logic in_token;
        logic in_quote;
        logic open_quote_single;
        logic escape_pending;
    } tok_state_t;

    // One result word
    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       token_first;
        logic       token_last;
    } tok_result_t;

endpackage : qat_pkg

`default_nettype wire

@@ rtl/qat_cfg.sv @@
// ----------------------------------------------------------------------------
// qat_cfg
// Separator mask registers and the per-byte separator lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [qat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qat_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [7:0]                     lookup_char,
    output logic                                is_sep
);
    import qat_pkg::*;

    logic [CFG_DATA_W-1:0] mask_reg [MASK_WORDS];

    // Write a mask word; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[0] <= SEP_MASK_0_RESET;
            mask_reg[1] <= '0;
            mask_reg[2] <= '0;
            mask_reg[3] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SEP_MASK_0: mask_reg[0] <= cfg_data;
                REG_SEP_MASK_1: mask_reg[1] <= cfg_data;
                REG_SEP_MASK_2: mask_reg[2] <= cfg_data;
                REG_SEP_MASK_3: mask_reg[3] <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Pick the flag: top two bits choose the word, low six the bit
    assign is_sep = mask_reg[lookup_char[7:6]][lookup_char[5:0]];

endmodule : qat_cfg

`default_nettype wire

@@ rtl/qat_core.sv @@
// ----------------------------------------------------------------------------
// qat_core
// Tokenizer state and the single-byte step: escape, quote and separator rules.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            cur_char,
    input  wire logic                  cur_eos,
    input  wire logic                  cur_sep,
    input  wire logic                  advance,
    output logic                       emit,
    output qat_pkg::tok_result_t       result
);
    import qat_pkg::*;

    tok_state_t state_reg;
    tok_state_t state_next;

    // Work out the result and next state for the byte in the input register
    always_comb
    begin
        logic       emit_char;
        logic [7:0] closer;
        state_next = state_reg;
        emit       = 1'b0;
        result     = '0;
        emit_char  = 1'b1;
        closer     = state_reg.open_quote_single ? CH_SQUOTE : CH_DQUOTE;

        if (state_reg.in_token || !cur_sep)
        begin
            state_next.in_token = 1'b1;
            if (state_reg.escape_pending)
            begin
                state_next.escape_pending = 1'b0;
            end
            else if (cur_char == CH_BSLASH)
            begin
                state_next.escape_pending = 1'b1;
            end
            else if (state_reg.in_quote)
            begin
                if (cur_char == closer)
                begin
                    state_next.in_quote = 1'b0;
                end
            end
            else if (cur_char == CH_DQUOTE || cur_char == CH_SQUOTE)
            begin
                state_next.in_quote          = 1'b1;
                state_next.open_quote_single = (cur_char == CH_SQUOTE);
            end
            else if (cur_sep)
            begin
                emit_char = 1'b0;
            end

            emit = 1'b1;
            if (emit_char)
            begin
                result.out_char    = cur_char;
                result.has_char    = 1'b1;
                result.token_first = !state_reg.in_token;
                result.token_last  = cur_eos;
            end
            else
            begin
                result.token_last   = 1'b1;
                state_next.in_token = 1'b0;
            end
        end

        // Drop all state at the end of the string
        if (cur_eos)
        begin
            state_next = '0;
        end
    end

    // Advance the state when the byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

endmodule : qat_core

`default_nettype wire

@@ rtl/quote_aware_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// quote_aware_tokenizer_top
// Streaming tokenizer: splits a byte string at separator runs, honouring
// quotes and backslash escapes, one result word per emitting byte.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | to block  | in_valid / in_ready  | in_char, end_of_string
//   out     | from block| out_valid / out_ready| out_char, has_char,
//           |           |                      | token_first, token_last
//   cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle sustained while the output is not stalled. A byte
// waits in the input register, where the step logic and mask lookup run,
// and then moves to the output register. Reset clears the tokenizer
// state and restores the space-only mask; no clearing pass. A stalled
// output holds the input register, and in_ready falls only when both
// registers are full and the held byte has a result.
// ----------------------------------------------------------------------------
`default_nettype none

module quote_aware_tokenizer_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     in_char,
    input  wire logic                           end_of_string,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [7:0]                          out_char,
    output logic                                has_char,
    output logic                                token_first,
    output logic                                token_last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [qat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qat_pkg::CFG_DATA_W-1:0] cfg_data
);
    import qat_pkg::*;

    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_eos_reg;
    logic        s1_sep;
    logic        s1_emit;
    logic        s1_advance;
    tok_result_t s1_result;
    logic        out_valid_reg;
    tok_result_t out_reg;

    assign cfg_ready = 1'b1;

    qat_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .lookup_char (s1_char_reg),
        .is_sep      (s1_sep)
    );

    qat_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cur_char (s1_char_reg),
        .cur_eos  (s1_eos_reg),
        .cur_sep  (s1_sep),
        .advance  (s1_advance),
        .emit     (s1_emit),
        .result   (s1_result)
    );

    // Move the held byte on when it has no result or its result has somewhere to go
    assign s1_advance = s1_valid_reg && (!s1_emit || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= in_char;
            s1_eos_reg  <= end_of_string;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_emit)
        begin
            out_reg <= s1_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_reg.out_char;
    assign has_char    = out_reg.has_char;
    assign token_first = out_reg.token_first;
    assign token_last  = out_reg.token_last;

endmodule : quote_aware_tokenizer_top

`default_nettype wire
